### hdl/rotate_drive_rotate_planner_macros.svh
`ifndef ROTATE_DRIVE_ROTATE_PLANNER_MACROS_SVH
`define ROTATE_DRIVE_ROTATE_PLANNER_MACROS_SVH

// concurrent check, switched off while reset is high
`define RDRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs through reset
`define RDRP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rdrp_pkg.sv
package rdrp_pkg;

  localparam int POS_W     = 13;
  localparam int HEAD_W    = 16;
  localparam int DIST_W    = 15;
  localparam int DELTA_W   = 14;
  localparam int SQR_W     = 26;
  localparam int RAD_W     = 28;
  localparam int ROOT_W    = 14;
  localparam int VEC_SHIFT = 20;
  localparam int VEC_W     = 37;
  localparam int TAB_LEN   = 24;
  localparam int TAB_FRAC  = 24;
  localparam int Z_W       = 34;
  localparam int IN_W      = 88;
  localparam int OUT_W     = 48;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [Z_W-1:0]     zacc_t;
  typedef logic [RAD_W-1:0]          rad_t;
  typedef logic [ROOT_W-1:0]         root_t;
  typedef logic [DIST_W-1:0]         mag_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic [3:0]               pad;
    logic signed [HEAD_W-1:0] goal_heading;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [HEAD_W-1:0] start_heading;
    logic signed [POS_W-1:0]  start_y;
    logic signed [POS_W-1:0]  start_x;
  } in_word_t;

  typedef struct packed {
    logic                     pad;
    logic signed [HEAD_W-1:0] final_turn;
    logic signed [HEAD_W-1:0] first_turn;
    logic signed [DIST_W-1:0] travel_distance;
  } out_word_t;

  // atan(2^-i) in degrees, scaled by 2^24
  function automatic zacc_t atan_entry(input int idx);
    zacc_t val;
    case (idx)
      0:  val = 34'sd754974720;
      1:  val = 34'sd445687602;
      2:  val = 34'sd235489088;
      3:  val = 34'sd119537938;
      4:  val = 34'sd60000934;
      5:  val = 34'sd30029717;
      6:  val = 34'sd15018523;
      7:  val = 34'sd7509720;
      8:  val = 34'sd3754917;
      9:  val = 34'sd1877466;
      10: val = 34'sd938734;
      11: val = 34'sd469367;
      12: val = 34'sd234684;
      13: val = 34'sd117342;
      14: val = 34'sd58671;
      15: val = 34'sd29335;
      16: val = 34'sd14668;
      17: val = 34'sd7334;
      18: val = 34'sd3667;
      19: val = 34'sd1833;
      20: val = 34'sd917;
      21: val = 34'sd458;
      22: val = 34'sd229;
      23: val = 34'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hdl/rdrp_delay.sv
module rdrp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  rdrp_pkg::pipe_ctl_t ctl,
  input  logic [W-1:0]        din,
  output logic                vout,
  output logic [W-1:0]        dout
);

  generate
    if (DEPTH == 0) begin : g_pass
      assign vout = ctl.valid;
      assign dout = din;
    end else begin : g_line
      logic [DEPTH-1:0] vline;
      logic [W-1:0]     dline [DEPTH];

      always_ff @(posedge clk) begin
        if (rst) begin
          vline <= '0;
        end else if (ctl.en) begin
          vline[0] <= ctl.valid;
          for (int i = 1; i < DEPTH; i++) begin
            vline[i] <= vline[i-1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (ctl.en) begin
          dline[0] <= din;
          for (int i = 1; i < DEPTH; i++) begin
            dline[i] <= dline[i-1];
          end
        end
      end

      assign vout = vline[DEPTH-1];
      assign dout = dline[DEPTH-1];
    end
  endgenerate

endmodule

### hdl/rdrp_dist.sv
module rdrp_dist (
  input  logic                  clk,
  input  logic                  rst,
  input  rdrp_pkg::pipe_ctl_t   ctl,
  input  rdrp_pkg::delta_t      dx,
  input  rdrp_pkg::delta_t      dy,
  output logic                  vout,
  output rdrp_pkg::mag_t        dist_mag
);

  localparam int RW = rdrp_pkg::ROOT_W;

  // valid per stage: squares, sum, one per root bit, rounding
  logic [RW+2:0] vs;

  logic signed [2*rdrp_pkg::DELTA_W-1:0] dxw_c, dyw_c, px_c, py_c;
  logic [rdrp_pkg::SQR_W-1:0] sq_x, sq_y;
  rdrp_pkg::rad_t rem  [RW+1];
  rdrp_pkg::root_t root [RW+1];

  always_comb begin
    dxw_c = {{rdrp_pkg::DELTA_W{dx[rdrp_pkg::DELTA_W-1]}}, dx};
    dyw_c = {{rdrp_pkg::DELTA_W{dy[rdrp_pkg::DELTA_W-1]}}, dy};
    px_c  = dxw_c * dxw_c;
    py_c  = dyw_c * dyw_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (ctl.en) begin
      vs <= {vs[RW+1:0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sq_x    <= px_c[rdrp_pkg::SQR_W-1:0];
      sq_y    <= py_c[rdrp_pkg::SQR_W-1:0];
      rem[0]  <= {2'b00, sq_x} + {2'b00, sq_y};
      root[0] <= '0;
    end
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < RW; j++) begin : g_root
    localparam int B = RW - 1 - j;
    rdrp_pkg::rad_t trial;

    always_comb begin
      trial = (rdrp_pkg::rad_t'(root[j]) << (B + 1)) | (rdrp_pkg::rad_t'(1) << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (rem[j] >= trial) begin
          rem[j+1]  <= rem[j] - trial;
          root[j+1] <= root[j] | (rdrp_pkg::root_t'(1) << B);
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j];
        end
      end
    end
  end

  // round to nearest: remainder above the root means the upper integer is closer
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dist_mag <= {1'b0, root[RW]} + rdrp_pkg::mag_t'(rem[RW] > rdrp_pkg::rad_t'(root[RW]));
    end
  end

  assign vout = vs[RW+2];

endmodule

### hdl/rdrp_cordic.sv
module rdrp_cordic #(
  parameter int CORDIC_STAGES       = 16,
  parameter int ANGLE_FRACTION_BITS = 7,
  parameter int ANG_W               = 19
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rdrp_pkg::pipe_ctl_t      ctl,
  input  rdrp_pkg::delta_t         dx,
  input  rdrp_pkg::delta_t         dy,
  output logic                     vout,
  output logic signed [ANG_W-1:0]  bearing
);

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam int N = (CORDIC_STAGES > rdrp_pkg::TAB_LEN) ? rdrp_pkg::TAB_LEN : CORDIC_STAGES;
  localparam int RND_SH = rdrp_pkg::TAB_FRAC - ANGLE_FRACTION_BITS;
  localparam rdrp_pkg::zacc_t Z_HALF = rdrp_pkg::zacc_t'(64'sd180 <<< rdrp_pkg::TAB_FRAC);

  rdrp_pkg::vec_t  x0_c, y0_c;
  rdrp_pkg::zacc_t z0_c, zr_c, zs_c;
  rdrp_pkg::vec_t  xs [N+1];
  rdrp_pkg::vec_t  ys [N+1];
  rdrp_pkg::zacc_t zs [N+1];
  logic [N:0]      zero_s;
  logic [N+1:0]    vs;

  // bring the vector into the right half plane, preset +-180
  always_comb begin
    x0_c = rdrp_pkg::vec_t'(dy) <<< rdrp_pkg::VEC_SHIFT;
    y0_c = rdrp_pkg::vec_t'(dx) <<< rdrp_pkg::VEC_SHIFT;
    z0_c = '0;
    if (dy < 0) begin
      z0_c = (dx >= 0) ? Z_HALF : -Z_HALF;
      x0_c = -x0_c;
      y0_c = -y0_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (ctl.en) begin
      vs <= {vs[N:0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      xs[0]     <= x0_c;
      ys[0]     <= y0_c;
      zs[0]     <= z0_c;
      zero_s[0] <= (dx == 0) && (dy == 0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        zero_s[i+1] <= zero_s[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + rdrp_pkg::atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - rdrp_pkg::atan_entry(i);
        end
      end
    end
  end

  // round half up to the output angle format
  always_comb begin
    zr_c = zs[N] + (rdrp_pkg::zacc_t'(1) <<< (RND_SH - 1));
    zs_c = zr_c >>> RND_SH;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      bearing <= zero_s[N] ? '0 : ang_t'(zs_c);
    end
  end

  assign vout = vs[N+1];

endmodule

### hdl/rdrp_turns.sv
module rdrp_turns #(
  parameter int ANGLE_FRACTION_BITS = 7,
  parameter int ANG_W               = 19
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rdrp_pkg::pipe_ctl_t                     ctl,
  input  logic signed [ANG_W-1:0]                 bearing,
  input  logic signed [rdrp_pkg::HEAD_W-1:0]      start_heading,
  input  logic signed [rdrp_pkg::HEAD_W-1:0]      goal_heading,
  input  rdrp_pkg::mag_t                          dist_mag,
  output logic                                    vout,
  output logic signed [rdrp_pkg::DIST_W-1:0]      travel_distance,
  output logic signed [rdrp_pkg::HEAD_W-1:0]      first_turn,
  output logic signed [rdrp_pkg::HEAD_W-1:0]      final_turn
);

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t HALF    = ang_t'(180 * (1 << ANGLE_FRACTION_BITS));
  localparam ang_t FULL    = ang_t'(360 * (1 << ANGLE_FRACTION_BITS));
  localparam ang_t QUARTER = ang_t'(90 * (1 << ANGLE_FRACTION_BITS));
  // enough whole-turn steps for any heading pattern against any bearing
  localparam int WRAP_STEPS =
    (540 * (1 << ANGLE_FRACTION_BITS) + 32768) / (360 * (1 << ANGLE_FRACTION_BITS));

  function automatic ang_t wrap_once(input ang_t v);
    ang_t r;
    r = v;
    if (v > HALF) begin
      r = v - FULL;
    end else if (v < -HALF) begin
      r = v + FULL;
    end
    return r;
  endfunction

  function automatic ang_t wrap_full(input ang_t v);
    ang_t r;
    r = v;
    for (int k = 0; k < WRAP_STEPS; k++) begin
      r = wrap_once(r);
    end
    return r;
  endfunction

  logic [1:0]     vs;
  ang_t           ta0, ta1;
  rdrp_pkg::mag_t dist_a;
  ang_t           t0_c, t1_c;
  logic           flip_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (ctl.en) begin
      vs <= {vs[0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ta0    <= wrap_full(bearing - ang_t'(start_heading));
      ta1    <= wrap_full(ang_t'(goal_heading) - bearing);
      dist_a <= dist_mag;
    end
  end

  // more than a quarter turn away: face the other way and back up
  always_comb begin
    flip_c = (ta0 > QUARTER) || (ta0 < -QUARTER);
    t0_c   = flip_c ? wrap_once(ta0 + HALF) : ta0;
    t1_c   = flip_c ? wrap_once(ta1 + HALF) : ta1;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      travel_distance <= flip_c ? -$signed(dist_a) : $signed(dist_a);
      first_turn      <= t0_c[rdrp_pkg::HEAD_W-1:0];
      final_turn      <= t1_c[rdrp_pkg::HEAD_W-1:0];
    end
  end

  assign vout = vs[1];

endmodule

### hdl/rotate_drive_rotate_planner.sv
// Rotate-drive-rotate planner: turns a start pose and a goal pose into a first
// turn on the spot, a signed straight drive and a final turn on the spot.
// Input word (s_axis): start x/y, start heading, goal x/y, goal heading.
// Output word (m_axis): travel distance in mm (negative = reverse), first turn
// and final turn, both wrapped to +-180 degrees.
// From the input handshake to m_axis_tvalid a word passes the input register, the
// CORDIC chain (one micro-rotation per stage) and the square root (one root bit
// per stage), which run side by side, then the turn registers and the output register.
// Throughput is one word per cycle unless the sink stalls: every stage is a
// register with a valid bit; a word can enter on any clock with s_axis_tready high.
// A two-entry output buffer (output register plus skid register) sits at the
// end. s_axis_tready is low only while the skid register is full, so a stalled
// sink freezes the whole pipeline without losing or repeating any word.
// Synchronous reset clears all valid bits and both output entries; data
// registers keep whatever they held. No state survives between words.
module rotate_drive_rotate_planner #(
  parameter int CORDIC_STAGES       = 16,
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // start_x, start_y, start_heading, goal_x, goal_y, goal_heading, zero pad
  input  logic [rdrp_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // travel_distance, first_turn, final_turn, zero pad
  output logic [rdrp_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int CORDIC_N   = (CORDIC_STAGES > rdrp_pkg::TAB_LEN) ?
                              rdrp_pkg::TAB_LEN : CORDIC_STAGES;
  localparam int CORDIC_LAT = CORDIC_N + 2;
  localparam int DIST_LAT   = rdrp_pkg::ROOT_W + 3;
  localparam int ALIGN_LAT  = (CORDIC_LAT > DIST_LAT) ? CORDIC_LAT : DIST_LAT;
  localparam int ANG_W      = (ANGLE_FRACTION_BITS + 12 > 18) ? ANGLE_FRACTION_BITS + 12 : 18;

  rdrp_pkg::in_word_t  in_w;
  rdrp_pkg::out_word_t pipe_w, out_w, skid_w;
  rdrp_pkg::pipe_ctl_t ctl1, bear_ctl, dist_ctl, turn_ctl;

  logic en, skid_valid;
  logic v1;
  rdrp_pkg::delta_t dx1, dy1;
  logic signed [rdrp_pkg::HEAD_W-1:0] h0_1, h1_1;

  logic                    cor_v, dist_v;
  logic signed [ANG_W-1:0] bearing;
  rdrp_pkg::mag_t          dist_mag;

  logic                    bear_v_d, dist_v_d, head_v_d;
  logic [ANG_W-1:0]        bear_d;
  rdrp_pkg::mag_t          dist_d;
  logic [2*rdrp_pkg::HEAD_W-1:0] head_d;

  logic tv;
  logic signed [rdrp_pkg::DIST_W-1:0] t_dist;
  logic signed [rdrp_pkg::HEAD_W-1:0] t_first, t_final;

  assign in_w          = rdrp_pkg::in_word_t'(s_axis_tdata);
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= rdrp_pkg::delta_t'(in_w.goal_x) - rdrp_pkg::delta_t'(in_w.start_x);
      dy1  <= rdrp_pkg::delta_t'(in_w.goal_y) - rdrp_pkg::delta_t'(in_w.start_y);
      h0_1 <= in_w.start_heading;
      h1_1 <= in_w.goal_heading;
    end
  end

  assign ctl1.en     = en;
  assign ctl1.valid  = v1;

  rdrp_cordic #(
    .CORDIC_STAGES       (CORDIC_STAGES),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .ANG_W               (ANG_W)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl1),
    .dx      (dx1),
    .dy      (dy1),
    .vout    (cor_v),
    .bearing (bearing)
  );

  rdrp_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl1),
    .dx       (dx1),
    .dy       (dy1),
    .vout     (dist_v),
    .dist_mag (dist_mag)
  );

  // line up the shorter of the two paths, and the headings, with the longer
  assign bear_ctl.en    = en;
  assign bear_ctl.valid = cor_v;
  assign dist_ctl.en    = en;
  assign dist_ctl.valid = dist_v;

  rdrp_delay #(
    .W     (ANG_W),
    .DEPTH (ALIGN_LAT - CORDIC_LAT)
  ) u_bear_dly (
    .clk  (clk),
    .rst  (rst),
    .ctl  (bear_ctl),
    .din  (bearing),
    .vout (bear_v_d),
    .dout (bear_d)
  );

  rdrp_delay #(
    .W     (rdrp_pkg::DIST_W),
    .DEPTH (ALIGN_LAT - DIST_LAT)
  ) u_dist_dly (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dist_ctl),
    .din  (dist_mag),
    .vout (dist_v_d),
    .dout (dist_d)
  );

  rdrp_delay #(
    .W     (2 * rdrp_pkg::HEAD_W),
    .DEPTH (ALIGN_LAT)
  ) u_head_dly (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl1),
    .din  ({h1_1, h0_1}),
    .vout (head_v_d),
    .dout (head_d)
  );

  assign turn_ctl.en    = en;
  assign turn_ctl.valid = bear_v_d && dist_v_d && head_v_d;

  rdrp_turns #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .ANG_W               (ANG_W)
  ) u_turns (
    .clk             (clk),
    .rst             (rst),
    .ctl             (turn_ctl),
    .bearing         (bear_d),
    .start_heading   (head_d[rdrp_pkg::HEAD_W-1:0]),
    .goal_heading    (head_d[2*rdrp_pkg::HEAD_W-1:rdrp_pkg::HEAD_W]),
    .dist_mag        (dist_d),
    .vout            (tv),
    .travel_distance (t_dist),
    .first_turn      (t_first),
    .final_turn      (t_final)
  );

  always_comb begin
    pipe_w                 = '0;
    pipe_w.travel_distance = t_dist;
    pipe_w.first_turn      = t_first;
    pipe_w.final_turn      = t_final;
  end

  // output register plus skid register; the pipeline only moves while skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= skid_valid || tv;
      skid_valid    <= 1'b0;
    end else if (tv && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      out_w <= skid_valid ? skid_w : pipe_w;
    end else if (en) begin
      skid_w <= pipe_w;
    end
  end

  assign m_axis_tdata = out_w;

endmodule

### hdl/rdrp_checker.sv
`include "rotate_drive_rotate_planner_macros.svh"

module rdrp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [rdrp_pkg::OUT_W-1:0] m_axis_tdata
);

  // a held output word must not change
  `RDRP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  // reset empties the output side and opens the input
  `RDRP_ASSERT_ALWAYS(a_reset_clear, rst |=> !m_axis_tvalid && s_axis_tready, "reset did not clear the output")

  // input back-pressure only follows a stalled output word
  `RDRP_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled with no output stall")

  // drive length never exceeds the field diagonal
  `RDRP_ASSERT(a_dist_range, m_axis_tvalid |-> $signed(m_axis_tdata[14:0]) <= 15'sd11586 && $signed(m_axis_tdata[14:0]) >= -15'sd11586, "travel distance out of range")

endmodule

bind rotate_drive_rotate_planner rdrp_checker u_rdrp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
